### hw/rtl/sorted_region_coalescer_assert.svh
// Assertion macros shared by the region coalescer RTL.
`ifndef SORTED_REGION_COALESCER_ASSERT_SVH
`define SORTED_REGION_COALESCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/src_pkg.sv
// Types, codes and helper functions for the sorted region coalescer.
`timescale 1ns / 1ps
`default_nettype none

package src_pkg;

  localparam logic [52:0] PAGE_LIMIT = 53'h10000000000000;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [3:0] STAT_CLEARED  = 4'd0;
  localparam logic [3:0] STAT_SKIPPED  = 4'd1;
  localparam logic [3:0] STAT_MERGE_L  = 4'd2;
  localparam logic [3:0] STAT_MERGE_R  = 4'd3;
  localparam logic [3:0] STAT_MERGE_B  = 4'd4;
  localparam logic [3:0] STAT_INSERTED = 4'd5;
  localparam logic [3:0] STAT_FULL     = 4'd6;
  localparam logic [3:0] STAT_OVERLAP  = 4'd7;
  localparam logic [3:0] STAT_READ     = 4'd8;

  localparam logic REG_MMIO = 1'b0;
  localparam logic REG_PORT = 1'b1;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_MERGE_L = 3'd1;
  localparam logic [2:0] OP_MERGE_R = 3'd2;
  localparam logic [2:0] OP_MERGE_B = 3'd3;
  localparam logic [2:0] OP_INSERT  = 3'd4;

  // Broadcast to every cell while an item is being evaluated.
  typedef struct packed {
    logic        en;
    logic [51:0] start;
    logic [52:0] pages;
    logic [5:0]  idx;
  } eval_ctrl_t;

  // Broadcast to every cell when the table is updated.
  typedef struct packed {
    logic [2:0]  op;
    logic [51:0] start;
    logic [52:0] pages;
  } apply_ctrl_t;

  // Per-cell findings, registered at the end of evaluation.
  typedef struct packed {
    logic ovl;
    logic ladj;
    logic radj;
    logic hit;
  } cell_stat_t;

  function automatic logic [52:0] sat_add(input logic [52:0] a, input logic [52:0] b);
    logic [53:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, PAGE_LIMIT}) begin
      sat_add = PAGE_LIMIT;
    end else begin
      sat_add = s[52:0];
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/src_cell.sv
// One table slot: holds a region, classifies it against an item, and shifts or merges.
`timescale 1ns / 1ps
`default_nettype none

module src_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                     clk,
  input  src_pkg::eval_ctrl_t      ev,
  input  src_pkg::apply_ctrl_t     ap,
  input  logic [CNT_W-1:0]         count,
  input  logic                     after_prev,
  input  logic                     after_next,
  input  logic [51:0]              prev_base,
  input  logic [52:0]              prev_pages,
  input  logic [51:0]              next_base,
  input  logic [52:0]              next_pages,
  output logic                     after,
  output logic [51:0]              base,
  output logic [52:0]              pages,
  output src_pkg::cell_stat_t      stat,
  output logic [51:0]              rd_base,
  output logic [52:0]              rd_pages
);

  localparam int CW = (CNT_W > 6) ? CNT_W : 6;

  logic        valid;
  logic        gt;
  logic        is_left;
  logic        is_right;
  logic        is_tgt;
  logic [53:0] left_end;
  logic [53:0] item_end;
  logic [52:0] sum_now;

  logic        left_q;
  logic        right_q;
  logic        tgt_q;
  logic        shift_dn;
  logic        take_prev;
  logic [52:0] psum;
  logic [51:0] base_next;
  logic [52:0] pages_next;

  // The valid slots form a prefix of the chain and are sorted, so the cells
  // past the insert point are exactly those that are invalid or greater.
  assign valid    = CNT_W'(INDEX) < count;
  assign gt       = valid && (base > ev.start);
  assign after    = !valid || gt;
  assign is_left  = !after && after_next;
  assign is_right = gt && !after_prev;
  assign is_tgt   = after && !after_prev;

  assign left_end = {2'b00, base} + {1'b0, pages};
  assign item_end = {2'b00, ev.start} + {1'b0, ev.pages};
  assign sum_now  = src_pkg::sat_add(pages, ev.pages);

  always_ff @(posedge clk) begin
    if (ev.en) begin
      left_q    <= is_left;
      right_q   <= is_right;
      tgt_q     <= is_tgt;
      shift_dn  <= gt;
      take_prev <= after_prev;
      psum      <= sum_now;
      stat.ovl  <= (is_left && (left_end > {2'b00, ev.start}))
                || (is_right && (item_end > {2'b00, base}));
      stat.ladj <= is_left && (left_end == {2'b00, ev.start});
      stat.radj <= is_right && (item_end == {2'b00, base});
      stat.hit  <= valid && (CW'(INDEX) == CW'(ev.idx));
    end
  end

  always_comb begin
    base_next  = base;
    pages_next = pages;
    case (ap.op)
      src_pkg::OP_MERGE_L: begin
        if (left_q) begin
          pages_next = psum;
        end
      end
      src_pkg::OP_MERGE_R: begin
        if (right_q) begin
          base_next  = ap.start;
          pages_next = psum;
        end
      end
      src_pkg::OP_MERGE_B: begin
        // The right neighbor folds into the left one and the tail moves down.
        if (left_q) begin
          pages_next = src_pkg::sat_add(psum, next_pages);
        end else if (shift_dn) begin
          base_next  = next_base;
          pages_next = next_pages;
        end
      end
      src_pkg::OP_INSERT: begin
        if (tgt_q) begin
          base_next  = ap.start;
          pages_next = ap.pages;
        end else if (take_prev) begin
          base_next  = prev_base;
          pages_next = prev_pages;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    base  <= base_next;
    pages <= pages_next;
  end

  assign rd_base  = stat.hit ? base : '0;
  assign rd_pages = stat.hit ? pages : '0;

endmodule

`default_nettype wire

### hw/rtl/sorted_region_coalescer.sv
// Top level of the sorted region coalescer: control, result register and the cell chain.
//
//  Channel   Dir  Handshake                Contents
//  s_axis    in   tvalid/tready            tuser: command; tdata: descriptor and read index
//  m_axis    out  tvalid/tready            tuser: status, read_miss; tdata: count, region
//  cfg       in   cfg_we (no wait)         skipped descriptor type codes
//
// An item is handled in an evaluate state, in which every cell compares itself with the
// item, then in an update state, in which the chain shifts or merges and the result is
// registered. The next item is accepted in the update state when the result register is free.
// A stalled result holds the block in its update cycle until the result register frees.
// Synchronous reset clears the region count and control and resets the skipped codes to
// 11 and 12; slot contents are not cleared and only slots below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_region_coalescer_assert.svh"

module sorted_region_coalescer #(
  parameter int MAX_REGIONS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // desc_type [31:0], start_page [83:32], page_count [136:84], read_index [142:137]
  input  logic [143:0] s_axis_tdata,
  // command [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // region_count [6:0], region_base [58:7], region_pages [111:59]
  output logic [111:0] m_axis_tdata,
  // status [3:0], read_miss [4]
  output logic [4:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [31:0]      mmio_code;
  logic [31:0]      port_code;

  logic [1:0]       cmd_q;
  logic [31:0]      type_q;
  logic [51:0]      start_q;
  logic [52:0]      pages_q;
  logic [5:0]       idx_q;
  logic [52:0]      pages_clamped;

  logic             accept;
  logic             out_free;
  logic             apply_fire;

  logic [3:0]       out_status;
  logic             out_miss;
  logic [6:0]       out_count;
  logic [51:0]      out_base;
  logic [52:0]      out_pages;

  logic [3:0]       res_status;
  logic             res_miss;
  logic [51:0]      res_base;
  logic [52:0]      res_pages;
  logic [2:0]       res_op;

  src_pkg::eval_ctrl_t  ev;
  src_pkg::apply_ctrl_t ap;

  logic [MAX_REGIONS-1:0] after_v;
  logic [51:0]            base_v     [MAX_REGIONS];
  logic [52:0]            pages_v    [MAX_REGIONS];
  src_pkg::cell_stat_t    stat_v     [MAX_REGIONS];
  logic [51:0]            rd_base_v  [MAX_REGIONS];
  logic [52:0]            rd_pages_v [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] hit_vec;

  logic        any_ovl;
  logic        any_ladj;
  logic        any_radj;
  logic        any_hit;
  logic [51:0] sel_base;
  logic [52:0] sel_pages;
  logic        skip;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) || ((state == S_APPLY) && out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign apply_fire    = (state == S_APPLY) && out_free;

  assign pages_clamped = pages_q[52] ? src_pkg::PAGE_LIMIT : pages_q;
  assign skip          = (type_q == mmio_code) || (type_q == port_code);

  assign ev.en    = (state == S_EVAL);
  assign ev.start = start_q;
  assign ev.pages = pages_clamped;
  assign ev.idx   = idx_q;

  assign ap.op    = apply_fire ? res_op : src_pkg::OP_NONE;
  assign ap.start = start_q;
  assign ap.pages = pages_clamped;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= s_axis_tuser;
      type_q  <= s_axis_tdata[31:0];
      start_q <= s_axis_tdata[83:32];
      pages_q <= s_axis_tdata[136:84];
      idx_q   <= s_axis_tdata[142:137];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mmio_code <= 32'd11;
      port_code <= 32'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        src_pkg::REG_MMIO: mmio_code <= cfg_data;
        src_pkg::REG_PORT: port_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
      logic        nb_after_prev;
      logic        nb_after_next;
      logic [51:0] nb_prev_base;
      logic [52:0] nb_prev_pages;
      logic [51:0] nb_next_base;
      logic [52:0] nb_next_pages;

      if (gi == 0) begin : g_first
        assign nb_after_prev = 1'b0;
        assign nb_prev_base  = '0;
        assign nb_prev_pages = '0;
      end else begin : g_mid_prev
        assign nb_after_prev = after_v[gi-1];
        assign nb_prev_base  = base_v[gi-1];
        assign nb_prev_pages = pages_v[gi-1];
      end

      if (gi == MAX_REGIONS - 1) begin : g_last
        assign nb_after_next = 1'b1;
        assign nb_next_base  = '0;
        assign nb_next_pages = '0;
      end else begin : g_mid_next
        assign nb_after_next = after_v[gi+1];
        assign nb_next_base  = base_v[gi+1];
        assign nb_next_pages = pages_v[gi+1];
      end

      src_cell #(
        .INDEX(gi),
        .CNT_W(CNT_W)
      ) u_cell (
        .clk       (clk),
        .ev        (ev),
        .ap        (ap),
        .count     (count),
        .after_prev(nb_after_prev),
        .after_next(nb_after_next),
        .prev_base (nb_prev_base),
        .prev_pages(nb_prev_pages),
        .next_base (nb_next_base),
        .next_pages(nb_next_pages),
        .after     (after_v[gi]),
        .base      (base_v[gi]),
        .pages     (pages_v[gi]),
        .stat      (stat_v[gi]),
        .rd_base   (rd_base_v[gi]),
        .rd_pages  (rd_pages_v[gi])
      );

      assign hit_vec[gi] = stat_v[gi].hit;
    end
  endgenerate

  // Only the two neighbors of the item raise overlap or adjacency flags and only one
  // slot answers a read, so a plain OR collects the answer.
  always_comb begin
    any_ovl   = 1'b0;
    any_ladj  = 1'b0;
    any_radj  = 1'b0;
    sel_base  = '0;
    sel_pages = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      any_ovl   = any_ovl | stat_v[i].ovl;
      any_ladj  = any_ladj | stat_v[i].ladj;
      any_radj  = any_radj | stat_v[i].radj;
      sel_base  = sel_base | rd_base_v[i];
      sel_pages = sel_pages | rd_pages_v[i];
    end
  end

  assign any_hit = |hit_vec;

  always_comb begin
    res_status = src_pkg::STAT_SKIPPED;
    res_miss   = 1'b0;
    res_base   = '0;
    res_pages  = '0;
    res_op     = src_pkg::OP_NONE;
    count_next = count;
    case (cmd_q)
      src_pkg::CMD_CLEAR: begin
        res_status = src_pkg::STAT_CLEARED;
        count_next = '0;
      end
      src_pkg::CMD_INSERT: begin
        if (skip) begin
          res_status = src_pkg::STAT_SKIPPED;
        end else if (any_ovl) begin
          res_status = src_pkg::STAT_OVERLAP;
        end else if (any_ladj && any_radj) begin
          res_status = src_pkg::STAT_MERGE_B;
          res_op     = src_pkg::OP_MERGE_B;
          count_next = count - CNT_W'(1);
        end else if (any_ladj) begin
          res_status = src_pkg::STAT_MERGE_L;
          res_op     = src_pkg::OP_MERGE_L;
        end else if (any_radj) begin
          res_status = src_pkg::STAT_MERGE_R;
          res_op     = src_pkg::OP_MERGE_R;
        end else if (count == CNT_W'(MAX_REGIONS)) begin
          res_status = src_pkg::STAT_FULL;
        end else begin
          res_status = src_pkg::STAT_INSERTED;
          res_op     = src_pkg::OP_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      src_pkg::CMD_READ: begin
        res_status = src_pkg::STAT_READ;
        if (any_hit) begin
          res_base  = sel_base;
          res_pages = sel_pages;
        end else begin
          res_miss = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          state_next = accept ? S_EVAL : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_fire) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      out_status <= res_status;
      out_miss   <= res_miss;
      out_count  <= 7'(count_next);
      out_base   <= res_base;
      out_pages  <= res_pages;
    end
  end

  assign m_axis_tdata = {out_pages, out_base, out_count};
  assign m_axis_tuser = {out_miss, out_status};

  `SRC_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_REGIONS), "region count above capacity")
  `SRC_ASSERT_NEXT(a_accept_eval, accept, state == S_EVAL, "accepted item not evaluated next")
  `SRC_ASSERT_NOW(a_hit_onehot, state == S_APPLY, $onehot0(hit_vec), "several slots match a read")
  `SRC_ASSERT_NOW(a_merge_nonempty, apply_fire && (res_op == src_pkg::OP_MERGE_B),
                  count >= CNT_W'(2), "double merge with fewer than two regions")
  `SRC_ASSERT_NOW(a_miss_read, m_axis_tvalid && m_axis_tuser[4],
                  m_axis_tuser[3:0] == src_pkg::STAT_READ, "read miss on a non-read result")

endmodule

`default_nettype wire

### bench/region_table_checker.sv
// Checker for the sorted region coalescer: predicts every result item and compares it.
`timescale 1ns / 1ps

module region_table_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // desc_type [31:0], start_page [83:32], page_count [136:84], read_index [142:137]
  input  logic [143:0] s_axis_tdata,
  // command [1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // region_count [6:0], region_base [58:7], region_pages [111:59]
  input  logic [111:0] m_axis_tdata,
  // status [3:0], read_miss [4]
  input  logic [4:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  output int           mismatch_count,
  output int           pending_results
);

  localparam logic [31:0] MMIO_CODE_AT_RESET = 32'd11;
  localparam logic [31:0] PORT_CODE_AT_RESET = 32'd12;
  localparam int          REPORT_LIMIT       = 10;

  typedef struct packed {
    logic [3:0]  status;
    logic [6:0]  count;
    logic [51:0] base;
    logic [52:0] pages;
    logic        miss;
  } region_answer_t;

  logic [51:0]    slot_base [TABLE_DEPTH];
  logic [52:0]    slot_pages[TABLE_DEPTH];
  int             slot_total;
  logic [31:0]    skip_mmio;
  logic [31:0]    skip_port;
  region_answer_t expected_answers[$];
  region_answer_t got;
  region_answer_t want;
  logic           bad;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    slot_total      = 0;
    skip_mmio       = MMIO_CODE_AT_RESET;
    skip_port       = PORT_CODE_AT_RESET;
  end

  function automatic logic [52:0] capped_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'(src_pkg::PAGE_LIMIT)) ? src_pkg::PAGE_LIMIT : s[52:0];
  endfunction

  function automatic logic [3:0] insert_region(input logic [31:0] dtype,
                                               input logic [51:0] start,
                                               input logic [52:0] pages_in);
    logic [63:0] pages;
    logic [63:0] left_end;
    logic [63:0] right_base;
    logic [63:0] new_end;
    logic        left_adj;
    logic        right_adj;
    int          n;
    int          j;
    int          k;
    if (dtype == skip_mmio || dtype == skip_port) return src_pkg::STAT_SKIPPED;
    pages = 64'((pages_in > src_pkg::PAGE_LIMIT) ? src_pkg::PAGE_LIMIT : pages_in);
    n = slot_total;
    j = n;
    // Sorted position: first slot whose base is above the new start.
    while (j > 0 && slot_base[j - 1] > start) j--;
    new_end    = 64'(start) + pages;
    left_end   = '0;
    right_base = '0;
    if (j > 0) left_end = 64'(slot_base[j - 1]) + 64'(slot_pages[j - 1]);
    if (j < n) right_base = 64'(slot_base[j]);
    if (j > 0 && left_end > 64'(start)) return src_pkg::STAT_OVERLAP;
    if (j < n && new_end > right_base) return src_pkg::STAT_OVERLAP;
    left_adj  = (j > 0) && (left_end == 64'(start));
    right_adj = (j < n) && (new_end == right_base);
    if (left_adj && right_adj) begin
      slot_pages[j - 1] = capped_sum(64'(capped_sum(64'(slot_pages[j - 1]), pages)),
                                     64'(slot_pages[j]));
      for (k = j; k + 1 < n; k++) begin
        slot_base[k]  = slot_base[k + 1];
        slot_pages[k] = slot_pages[k + 1];
      end
      slot_total = n - 1;
      return src_pkg::STAT_MERGE_B;
    end
    if (left_adj) begin
      slot_pages[j - 1] = capped_sum(64'(slot_pages[j - 1]), pages);
      return src_pkg::STAT_MERGE_L;
    end
    if (right_adj) begin
      slot_base[j]  = start;
      slot_pages[j] = capped_sum(64'(slot_pages[j]), pages);
      return src_pkg::STAT_MERGE_R;
    end
    if (n >= TABLE_DEPTH) return src_pkg::STAT_FULL;
    for (k = n; k > j; k--) begin
      slot_base[k]  = slot_base[k - 1];
      slot_pages[k] = slot_pages[k - 1];
    end
    slot_base[j]  = start;
    slot_pages[j] = pages[52:0];
    slot_total    = n + 1;
    return src_pkg::STAT_INSERTED;
  endfunction

  function automatic region_answer_t predict_answer(input logic [1:0] cmd,
                                                    input logic [143:0] data);
    region_answer_t ans;
    ans = '0;
    case (cmd)
      src_pkg::CMD_CLEAR: begin
        slot_total = 0;
        ans.status = src_pkg::STAT_CLEARED;
      end
      src_pkg::CMD_INSERT: begin
        ans.status = insert_region(data[31:0], data[83:32], data[136:84]);
      end
      src_pkg::CMD_READ: begin
        ans.status = src_pkg::STAT_READ;
        if (int'(data[142:137]) < slot_total) begin
          ans.base  = slot_base[data[142:137]];
          ans.pages = slot_pages[data[142:137]];
        end else begin
          ans.miss = 1'b1;
        end
      end
      default: begin
        ans.status = src_pkg::STAT_SKIPPED;
      end
    endcase
    ans.count = slot_total[6:0];
    return ans;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      slot_total = 0;
      skip_mmio  = MMIO_CODE_AT_RESET;
      skip_port  = PORT_CODE_AT_RESET;
      expected_answers.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser[3:0];
        got.miss   = m_axis_tuser[4];
        got.count  = m_axis_tdata[6:0];
        got.base   = m_axis_tdata[58:7];
        got.pages  = m_axis_tdata[111:59];
        if (expected_answers.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: result item with nothing outstanding: status %0d count %0d",
                     $time, got.status, got.count);
          mismatch_count++;
        end else begin
          want = expected_answers.pop_front();
          bad  = (got.status !== want.status) || (got.count !== want.count) ||
                 (got.base !== want.base) || (got.pages !== want.pages) ||
                 (got.miss !== want.miss);
          if (bad) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: mismatch: expected status %0d count %0d base %h pages %h miss %0d",
                       $time, want.status, want.count, want.base, want.pages, want.miss);
              $display("%0t: mismatch: got status %0d count %0d base %h pages %h miss %0d",
                       $time, got.status, got.count, got.base, got.pages, got.miss);
            end
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_answers.push_back(predict_answer(s_axis_tuser, s_axis_tdata));
      if (cfg_we) begin
        if (cfg_index == src_pkg::REG_MMIO) skip_mmio = cfg_data;
        else skip_port = cfg_data;
      end
    end
    pending_results = expected_answers.size();
  end

endmodule

### bench/sorted_region_coalescer_tb.sv
// Testbench top for the sorted region coalescer: stimulus, idling, configuration and verdict.
`timescale 1ns / 1ps

module sorted_region_coalescer_tb;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [51:0] MAX_START     = 52'hF_FFFF_FFFF_FFFF;
  localparam logic [52:0] MAX_PAGES     = 53'h1F_FFFF_FFFF_FFFF;
  localparam int          FILL_SLOTS    = 70;
  localparam int          MIXED_ITEMS   = 230;
  localparam int          PHASES        = 6;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          DRAIN_LIMIT   = 20000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [4:0]   m_axis_tuser;
  logic         cfg_we;
  logic         cfg_index;
  logic [31:0]  cfg_data;
  int           mismatch_count;
  int           pending_results;
  int           send_idle_pct;
  int           recv_idle_pct;
  logic [31:0]  mmio_code;
  logic [31:0]  port_code;

  sorted_region_coalescer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  region_table_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("[sorted_region_coalescer] ERROR");
    $finish;
  end

  function automatic logic [51:0] rand52();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[51:0];
  endfunction

  function automatic logic [52:0] rand53();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[52:0];
  endfunction

  // Mostly small type codes, with the skipped codes hit on purpose.
  function automatic logic [31:0] pick_type();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return mmio_code;
    if (r == 1) return port_code;
    if (r < 8) return $urandom_range(0, 15);
    return $urandom;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] dtype,
                           input logic [51:0] start, input logic [52:0] pages,
                           input logic [5:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tuser  = cmd;
    s_axis_tdata  = {1'b0, idx, pages, start, dtype};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic insert_desc(input logic [31:0] dtype, input logic [51:0] start,
                             input logic [52:0] pages);
    send_item(src_pkg::CMD_INSERT, dtype, start, pages, 6'($urandom_range(0, 63)));
  endtask

  task automatic read_slot(input logic [5:0] idx);
    send_item(src_pkg::CMD_READ, $urandom, rand52(), rand53(), idx);
  endtask

  task automatic clear_table();
    send_item(src_pkg::CMD_CLEAR, $urandom, rand52(), rand53(), 6'($urandom_range(0, 63)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == src_pkg::REG_MMIO) mmio_code = value;
    else port_code = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Disjoint, non-adjacent regions in a shuffled order, enough to overflow the table.
  task automatic fill_table(input logic [51:0] anchor);
    int          k;
    int          offset;
    logic [31:0] dtype;
    clear_table();
    offset = $urandom_range(0, FILL_SLOTS - 1);
    for (k = 0; k < FILL_SLOTS; k++) begin
      dtype = $urandom_range(0, 15);
      while (dtype == mmio_code || dtype == port_code) dtype = $urandom_range(0, 15);
      insert_desc(dtype, anchor + 52'(3 * ((k * 37 + offset) % FILL_SLOTS)),
                  53'($urandom_range(0, 2)));
    end
  endtask

  task automatic send_mixed_item(input logic [51:0] anchor);
    int          pick;
    logic [52:0] pages;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      clear_table();
    end else if (pick < 3) begin
      send_item(CMD_UNUSED, $urandom, rand52(), rand53(), 6'($urandom_range(0, 63)));
    end else if (pick < 18) begin
      read_slot((pick < 10) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63)));
    end else if (pick < 28) begin
      insert_desc(pick_type(), rand52(), rand53());
    end else begin
      // Small regions packed in a narrow window so that merges and overlaps are common.
      pick = $urandom_range(0, 99);
      if (pick < 70) pages = 53'($urandom_range(0, 4));
      else if (pick < 90) pages = 53'($urandom_range(5, 64));
      else pages = rand53();
      insert_desc(pick_type(), anchor + 52'($urandom_range(0, 255)), pages);
    end
  endtask

  initial begin : stimulus
    int          phase;
    int          n;
    int          wait_cycles;
    logic [51:0] anchor;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = src_pkg::CMD_CLEAR;
    cfg_we        = 1'b0;
    cfg_index     = src_pkg::REG_MMIO;
    cfg_data      = '0;
    send_idle_pct = 25;
    recv_idle_pct = 81;
    mmio_code     = 32'd11;
    port_code     = 32'd12;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    read_slot(6'd0);
    insert_desc(32'd11, 52'd500, 53'd4);
    insert_desc(32'd12, 52'd600, 53'd4);
    insert_desc(32'd7, 52'd100, 53'd10);
    insert_desc(32'd0, 52'd110, 53'd5);
    insert_desc(32'd7, 52'd90, 53'd10);
    insert_desc(32'd7, 52'd200, 53'd10);
    insert_desc(32'd7, 52'd115, 53'd85);
    insert_desc(32'd7, 52'd150, 53'd1);
    insert_desc(32'd7, 52'd80, 53'd11);
    insert_desc(32'd7, 52'd300, 53'd0);
    insert_desc(32'd7, 52'd300, 53'd0);
    insert_desc(32'd7, 52'd0, MAX_PAGES);
    read_slot(6'd0);
    read_slot(6'd1);
    read_slot(6'd63);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF, MAX_START, MAX_PAGES, 6'd63);
    clear_table();
    insert_desc(32'hFFFF_FFFF, MAX_START, MAX_PAGES);
    read_slot(6'd0);
    clear_table();
    insert_desc(32'd3, 52'd10, 53'd10);
    // The merged count saturates at the page limit.
    insert_desc(32'd3, 52'd20, MAX_PAGES);
    read_slot(6'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      if (phase == 2) begin
        send_idle_pct = 81;
        recv_idle_pct = 25;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      anchor = rand52() & ~52'h3FF;
      case (phase)
        0: begin
          anchor = '0;
        end
        1: begin
          write_reg(src_pkg::REG_MMIO, 32'd0);
          write_reg(src_pkg::REG_PORT, 32'hFFFF_FFFF);
          anchor = MAX_START - 52'd300;
        end
        2: begin
          write_reg(src_pkg::REG_MMIO, 32'hFFFF_FFFF);
          write_reg(src_pkg::REG_PORT, 32'd0);
        end
        3: begin
          write_reg(src_pkg::REG_MMIO, 32'd5);
          write_reg(src_pkg::REG_PORT, 32'd5);
        end
        4: begin
          write_reg(src_pkg::REG_MMIO, $urandom_range(0, 15));
          write_reg(src_pkg::REG_PORT, $urandom);
        end
        default: begin
          write_reg(src_pkg::REG_MMIO, 32'd11);
          write_reg(src_pkg::REG_PORT, 32'd12);
        end
      endcase
      fill_table(anchor);
      // Let the full table drain completely before the mixed traffic.
      wait_drained();
      for (n = 0; n < MIXED_ITEMS; n++) send_mixed_item(anchor);
    end

    s_axis_tvalid = 1'b0;
    wait_cycles   = 0;
    while (pending_results != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (pending_results != 0) begin
      $display("[sorted_region_coalescer] ERROR");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (mismatch_count == 0) begin
        $display("[sorted_region_coalescer] OK");
      end else begin
        $display("[sorted_region_coalescer] ERROR");
      end
      $finish;
    end
  end

endmodule
